>>> design/uint64_arith_unit_assert.svh
// Assertion macros shared by the arithmetic unit modules.
`ifndef UINT64_ARITH_UNIT_ASSERT_SVH
`define UINT64_ARITH_UNIT_ASSERT_SVH

// Checks a property at every clock edge outside of reset.
`define UAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define UAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/uau_pkg.sv
// Types, constants and operation codes of the arithmetic unit.
package uau_pkg;

  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_BITS  = WORD_BYTES * 8;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HALF_W     = DATA_W / 2;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned DIV_SHIFT  = DATA_W - WORD_BITS;
  localparam int unsigned CNT_W      = $clog2(WORD_BITS + 1);

  localparam logic [DATA_W-1:0] WORD_MASK =
    (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MOD = 3'd4;
  localparam logic [OP_W-1:0] OP_CMP = 3'd5;

  localparam logic signed [1:0] SIGN_LESS    = -2'sd1;
  localparam logic signed [1:0] SIGN_EQUAL   = 2'sd0;
  localparam logic signed [1:0] SIGN_GREATER = 2'sd1;

  // Which part of the back end carries out a job.
  typedef enum logic [1:0] {
    KIND_ALU,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OP_W-1:0]   op;
    logic              div_zero;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
  } job_t;

endpackage

>>> design/uau_intf.sv
// Request and response channel interfaces of the arithmetic unit.
interface uau_req_if;
  logic                          valid;
  logic                          ready;
  logic [uau_pkg::OP_W-1:0]      req_type;
  logic [uau_pkg::DATA_W-1:0]    operand_a;
  logic [uau_pkg::DATA_W-1:0]    operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface

interface uau_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [uau_pkg::DATA_W-1:0]    result_value;
  logic signed [1:0]             compare_sign;
  logic                          underflow;
  logic                          divide_by_zero;

  modport source (output valid, output result_value, output compare_sign,
                  output underflow, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input compare_sign,
                  input underflow, input divide_by_zero, output ready);
endinterface

>>> design/uau_front.sv
// Front end: takes request beats, trims operands and classifies the operation.
module uau_front (
  uau_req_if.sink          req_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output uau_pkg::job_t    job_o
);
  import uau_pkg::*;

  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic              b_zero;

  assign opa    = req_i.operand_a & WORD_MASK;
  assign opb    = req_i.operand_b & WORD_MASK;
  assign b_zero = (opb == '0);

  always_comb begin
    job_o.op       = req_i.req_type;
    job_o.opa      = opa;
    job_o.opb      = opb;
    job_o.div_zero = 1'b0;
    job_o.kind     = KIND_ALU;
    case (req_i.req_type)
      OP_MUL: job_o.kind = KIND_MUL;
      OP_DIV, OP_MOD: begin
        // A zero divisor is settled at once by the ALU path.
        job_o.div_zero = b_zero;
        job_o.kind     = b_zero ? KIND_ALU : KIND_DIV;
      end
      default: job_o.kind = KIND_ALU;
    endcase
  end

  assign job_valid_o = req_i.valid;
  assign req_i.ready = job_ready_i;

endmodule

>>> design/uau_queue.sv
// Small job queue between the front end and the back end.
`include "uint64_arith_unit_assert.svh"

module uau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  uau_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output uau_pkg::job_t pop_data_o
);
  import uau_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `UAU_ASSERT(a_queue_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `UAU_ASSERT(a_queue_no_ovf, (count_q == QCNT_W'(QUEUE_DEPTH)) |-> !push, "push into full queue")
  `UAU_ASSERT(a_queue_no_udf, (count_q == '0) |-> !pop, "pop from empty queue")

endmodule

>>> design/uau_back.sv
// Back end: ALU, shared 32x32 multiplier and bit-serial divider.
`include "uint64_arith_unit_assert.svh"

module uau_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  uau_pkg::job_t job_i,
  uau_rsp_if.source     rsp_o
);
  import uau_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_value_q;
  logic signed [1:0]   out_sign_q;
  logic                out_under_q;
  logic                out_dz_q;

  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   opa_q;    // multiplicand, or dividend shifting out MSB first
  logic [DATA_W-1:0]   opb_q;    // multiplier, or divisor
  logic [DATA_W-1:0]   acc_q;    // product accumulator, or partial remainder
  logic [DATA_W-1:0]   quo_q;
  logic [DATA_W-1:0]   prod_q;
  logic [1:0]          mstep_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                out_free;
  logic                take;
  logic                out_set;

  // ALU results.
  logic [DATA_W-1:0]   alu_value;
  logic signed [1:0]   alu_sign;
  logic                alu_under;

  // Multiplier operand select.
  logic [HALF_W-1:0]   mul_x;
  logic [HALF_W-1:0]   mul_y;
  logic [HALF_W-1:0]   acc_hi_sum;

  // One restoring division step.
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     rem_diff;
  logic [DATA_W-1:0]   rem_nx;
  logic [DATA_W-1:0]   quo_nx;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign job_ready_o = (state_q == ST_IDLE) && out_free;
  assign take        = job_valid_i && job_ready_o;

  // A result is written when an ALU job is taken or a multiply or divide job finishes.
  assign out_set = (take && (job_i.kind != KIND_MUL) && (job_i.kind != KIND_DIV)) ||
                   ((state_q == ST_MUL) && (mstep_q == 2'd3)) ||
                   ((state_q == ST_DIV) && (cnt_q == CNT_W'(1)));

  always_comb begin
    alu_value = '0;
    alu_sign  = SIGN_EQUAL;
    alu_under = 1'b0;
    case (job_i.op)
      OP_ADD: alu_value = (job_i.opa + job_i.opb) & WORD_MASK;
      OP_SUB: begin
        alu_value = (job_i.opa - job_i.opb) & WORD_MASK;
        alu_under = (job_i.opb > job_i.opa);
      end
      OP_DIV: alu_value = '0;
      OP_MOD: alu_value = job_i.opa;
      OP_CMP: begin
        if (job_i.opa < job_i.opb) begin
          alu_sign = SIGN_LESS;
        end else if (job_i.opa > job_i.opb) begin
          alu_sign = SIGN_GREATER;
        end else begin
          alu_sign = SIGN_EQUAL;
        end
      end
      default: alu_value = '0;
    endcase
  end

  always_comb begin
    case (mstep_q)
      2'd1:    begin mul_x = opa_q[HALF_W-1:0];      mul_y = opb_q[DATA_W-1:HALF_W]; end
      2'd2:    begin mul_x = opa_q[DATA_W-1:HALF_W]; mul_y = opb_q[HALF_W-1:0];      end
      default: begin mul_x = opa_q[HALF_W-1:0];      mul_y = opb_q[HALF_W-1:0];      end
    endcase
  end

  assign acc_hi_sum = acc_q[DATA_W-1:HALF_W] + prod_q[HALF_W-1:0];

  assign rem_sh   = {acc_q, opa_q[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, opb_q};
  assign rem_nx   = rem_diff[DATA_W] ? rem_sh[DATA_W-1:0] : rem_diff[DATA_W-1:0];
  assign quo_nx   = {quo_q[DATA_W-2:0], !rem_diff[DATA_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_sign_q  <= SIGN_EQUAL;
      out_under_q <= 1'b0;
      out_dz_q    <= 1'b0;
      op_q        <= OP_ADD;
      opa_q       <= '0;
      opb_q       <= '0;
      acc_q       <= '0;
      quo_q       <= '0;
      prod_q      <= '0;
      mstep_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take) begin
            op_q  <= job_i.op;
            opb_q <= job_i.opb;
            unique case (job_i.kind)
              KIND_MUL: begin
                opa_q   <= job_i.opa;
                mstep_q <= '0;
                state_q <= ST_MUL;
              end
              KIND_DIV: begin
                opa_q   <= job_i.opa << DIV_SHIFT;
                acc_q   <= '0;
                quo_q   <= '0;
                cnt_q   <= CNT_W'(WORD_BITS);
                state_q <= ST_DIV;
              end
              default: begin
                out_value_q <= alu_value;
                out_sign_q  <= alu_sign;
                out_under_q <= alu_under;
                out_dz_q    <= job_i.div_zero;
              end
            endcase
          end
        end
        ST_MUL: begin
          // Both factors are half-word slices, so this is a 32x32 multiply.
          prod_q  <= DATA_W'(mul_x) * DATA_W'(mul_y);
          mstep_q <= mstep_q + 1'b1;
          case (mstep_q)
            2'd0: acc_q <= '0;
            2'd1: acc_q <= prod_q;
            2'd2: acc_q[DATA_W-1:HALF_W] <= acc_hi_sum;
            default: begin
              out_value_q <= {acc_hi_sum, acc_q[HALF_W-1:0]} & WORD_MASK;
              out_sign_q  <= SIGN_EQUAL;
              out_under_q <= 1'b0;
              out_dz_q    <= 1'b0;
              state_q     <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          acc_q <= rem_nx;
          quo_q <= quo_nx;
          opa_q <= {opa_q[DATA_W-2:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            out_value_q <= ((op_q == OP_MOD) ? rem_nx : quo_nx) & WORD_MASK;
            out_sign_q  <= SIGN_EQUAL;
            out_under_q <= 1'b0;
            out_dz_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_value   = out_value_q;
  assign rsp_o.compare_sign   = out_sign_q;
  assign rsp_o.underflow      = out_under_q;
  assign rsp_o.divide_by_zero = out_dz_q;

  `UAU_ASSERT(a_busy_out_empty, (state_q != ST_IDLE) |-> !out_valid_q, "result held while busy")
  `UAU_ASSERT(a_div_count_live, (state_q == ST_DIV) |-> (cnt_q != '0), "divider count ran out")
  `UAU_ASSERT_NEXT(a_mul_done, (state_q == ST_MUL) && (mstep_q == 2'd3), out_valid_q && (state_q == ST_IDLE), "multiply did not finish")

endmodule

>>> design/uint64_arith_unit.sv
// Top level of the unsigned 64-bit arithmetic unit with divider.
// Add, subtract, compare, unknown codes and zero divisors go through the ALU at one beat per
// cycle while the sink is ready; multiply runs three partial products on a shared 32x32
// multiplier, and divide and modulus run a bit-serial divider loop. The back end takes no
// new job until the current one has finished.
// Reset is asynchronous and active low; it empties the job queue and the result register.
module uint64_arith_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  uau_req_if.sink   req_i,
  uau_rsp_if.source rsp_o
);
  import uau_pkg::*;

  // The front end trims both operands to the word width and tags each job with the unit
  // that will run it. Zero-divisor divides are tagged for the ALU path, so the
  // divider only ever sees a nonzero divisor.
  logic job_valid;
  logic job_ready;
  job_t job;

  // The queue decouples acceptance from execution: the front end keeps taking beats, up to two
  // queued jobs, while the back end grinds through a long divide or a result waits for the sink.
  logic q_valid;
  logic q_ready;
  job_t q_job;

  uau_front u_front (
    .req_i       (req_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  uau_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  // The back end pops one job at a time, only when its result register is free or being
  // drained this cycle, and writes exactly one result beat per job.
  uau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .rsp_o       (rsp_o)
  );

endmodule

>>> dv/tb_uint64_arith_unit.sv
// Self-checking testbench for the unsigned 64-bit arithmetic unit with divider.
`timescale 1ns / 1ps

module tb_uint64_arith_unit;
  import uau_pkg::*;

  // Codes 6 and 7 are not operations; the unit answers them with an all-zero result.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};

  localparam int unsigned RANDOM_ITEMS = 950;
  // A divide is the longest job; a stalled receiver and a paused sender hold things
  // up further. Anything far beyond that without a beat means the unit is stuck.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = WORD_BITS + 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic signed [1:0] sign;
    logic              under;
    logic              dz;
  } arith_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uau_req_if req_if ();
  uau_rsp_if rsp_if ();

  uint64_arith_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  arith_req_t  req_queue [$];      // requests not yet offered to the unit
  arith_rsp_t  result_queue [$];   // predicted results, oldest first
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned op_count [8];
  int unsigned dz_count;
  int unsigned under_count;
  int unsigned gap_left;
  int unsigned stall_left;

  // Computes the result the unit must give for one request. Operands and results
  // are cut to the word width; fields that do not belong to the operation stay 0.
  function automatic arith_rsp_t arith_predict(arith_req_t r);
    arith_rsp_t        p;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    p = '0;
    a = r.a & WORD_MASK;
    b = r.b & WORD_MASK;
    case (r.op)
      OP_ADD: p.value = (a + b) & WORD_MASK;
      OP_SUB: begin
        p.value = (a - b) & WORD_MASK;
        p.under = (b > a);
      end
      OP_MUL: p.value = (a * b) & WORD_MASK;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          // A zero divisor gives quotient 0 and hands the dividend back as remainder.
          p.dz    = 1'b1;
          p.value = (r.op == OP_DIV) ? '0 : a;
        end else begin
          p.value = ((r.op == OP_DIV) ? (a / b) : (a % b)) & WORD_MASK;
        end
      end
      OP_CMP: p.sign = (a < b) ? SIGN_LESS : ((a > b) ? SIGN_GREATER : SIGN_EQUAL);
      default: ;
    endcase
    return p;
  endfunction

  // Operands lean toward the corners: zero, all ones, single bits, small and
  // near-maximum values, and shortened random words, besides plain random words.
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ALL_ONES;
      2: begin
        v = '0;
        v[$urandom_range(0, DATA_W-1)] = 1'b1;
      end
      3: v = DATA_W'($urandom_range(0, 255));
      4: begin
        v = DATA_W'($urandom_range(0, 255));
        v = ~v;
      end
      5: v = v >> $urandom_range(1, DATA_W-1);
      default: ;
    endcase
    return v;
  endfunction

  // Pause drawn before the next beat on either side. Every fourth stretch of
  // 100 beats runs with no pauses at all, so back-to-back traffic is covered too.
  function automatic int unsigned draw_wait(int unsigned idx);
    return ((idx / 100) % 4 == 3) ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    arith_req_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    req_queue.push_back(r);
  endtask

  task automatic check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch on result %0d, expected %0h, actual %0h",
               $time, what, results_seen, want, got);
    end
  endtask

  // Request driver. A beat is taken at an edge where valid and ready are both high;
  // the prediction for it is queued right there, from the fields that were on the bus.
  always @(posedge clk_i) begin
    arith_req_t acc;
    arith_req_t nxt;
    arith_rsp_t p;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc.op = req_if.req_type;
        acc.a  = req_if.operand_a;
        acc.b  = req_if.operand_b;
        p = arith_predict(acc);
        result_queue.push_back(p);
        items_sent++;
        op_count[acc.op]++;
        dz_count    += p.dz;
        under_count += p.under;
      end
      // The bus may only change when it holds no beat or the beat just went through.
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          req_if.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (req_queue.size() != 0) begin
          nxt = req_queue.pop_front();
          req_if.valid     <= 1'b1;
          req_if.req_type  <= nxt.op;
          req_if.operand_a <= nxt.a;
          req_if.operand_b <= nxt.b;
          gap_left         <= draw_wait(items_sent);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result beat is checked against the oldest prediction, then
  // ready is held low for a drawn number of cycles before the next beat is taken.
  always @(posedge clk_i) begin
    arith_rsp_t  got;
    arith_rsp_t  want;
    int unsigned n;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      got.value = rsp_if.result_value;
      got.sign  = rsp_if.compare_sign;
      got.under = rsp_if.underflow;
      got.dz    = rsp_if.divide_by_zero;
      if (result_queue.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing outstanding, expected none, actual value %0h",
                 $time, got.value);
      end else begin
        want = result_queue.pop_front();
        check_field("result_value", want.value, got.value);
        check_field("compare_sign", DATA_W'(want.sign), DATA_W'(got.sign));
        check_field("underflow", DATA_W'(want.under), DATA_W'(got.under));
        check_field("divide_by_zero", DATA_W'(want.dz), DATA_W'(got.dz));
      end
      results_seen++;
      n = draw_wait(results_seen);
      stall_left   <= n;
      rsp_if.ready <= (n == 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= (stall_left == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, result_queue.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    int unsigned       k;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready     = 1'b0;

    // Directed corners: carries and wraps, underflow, zero divisors, quotients of
    // zero and of the full word, the top dividend bit, unsigned compare order, and
    // the two unused codes.
    add_req(OP_ADD, ALL_ONES, 64'd1);
    add_req(OP_ADD, ALL_ONES, ALL_ONES);
    add_req(OP_ADD, '0, '0);
    add_req(OP_SUB, '0, 64'd1);
    add_req(OP_SUB, ALL_ONES, ALL_ONES);
    add_req(OP_SUB, ALL_ONES, '0);
    add_req(OP_MUL, ALL_ONES, ALL_ONES);
    add_req(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    add_req(OP_MUL, '0, ALL_ONES);
    add_req(OP_DIV, ALL_ONES, 64'd1);
    add_req(OP_DIV, 64'd5, '0);
    add_req(OP_DIV, 64'd3, ALL_ONES);
    add_req(OP_DIV, ALL_ONES, ALL_ONES);
    add_req(OP_DIV, TOP_BIT, 64'd3);
    add_req(OP_DIV, '0, '0);
    add_req(OP_MOD, ALL_ONES, '0);
    add_req(OP_MOD, '0, '0);
    add_req(OP_MOD, ALL_ONES, TOP_BIT | 64'd1);
    add_req(OP_MOD, 64'd7, ALL_ONES);
    add_req(OP_CMP, '0, ALL_ONES);
    add_req(OP_CMP, ALL_ONES, ALL_ONES);
    add_req(OP_CMP, ALL_ONES, '0);
    add_req(OP_CMP, TOP_BIT, ~TOP_BIT);
    add_req(OP_UNUSED_LO, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    add_req(OP_UNUSED_HI, ALL_ONES, ALL_ONES);

    // Random part: mostly real operations, a few unused codes. Zero divisors and
    // equal operands are forced now and then, since random words rarely hit them.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      k = $urandom_range(0, 99);
      if (k < 2) begin
        op = OP_UNUSED_LO;
      end else if (k < 4) begin
        op = OP_UNUSED_HI;
      end else begin
        op = OP_W'($urandom_range(OP_ADD, OP_CMP));
      end
      a = pick_operand();
      b = pick_operand();
      k = $urandom_range(0, 99);
      if ((op == OP_DIV || op == OP_MOD) && k < 8) begin
        b = '0;
      end else if ((op == OP_SUB || op == OP_CMP) && k < 15) begin
        b = a;
      end
      add_req(op, a, b);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_queue.size() != 0 || req_if.valid || result_queue.size() != 0) begin
      @(posedge clk_i);
    end
    // Give a stray extra result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: add %0d, sub %0d, mul %0d, div %0d,",
             items_sent, results_seen, op_count[OP_ADD], op_count[OP_SUB],
             op_count[OP_MUL], op_count[OP_DIV]);
    $display("mod %0d, cmp %0d, unused codes %0d; %0d zero divisors, %0d underflows.",
             op_count[OP_MOD], op_count[OP_CMP],
             op_count[OP_UNUSED_LO] + op_count[OP_UNUSED_HI], dz_count, under_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
